[src/jpss_pkg.sv]
// Shared types, constants and direction helpers for the jump point successor search.
package jpss_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int COORD_W        = 6;
   localparam int COST_W         = 14;
   localparam int CSR_DATA_W     = 8;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [3:0] DIR_NONE     = 4'd8;
   localparam logic [7:0] DIR_MASK_ALL = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GRID_WIDTH    = 3'd0,
      REG_GRID_HEIGHT   = 3'd1,
      REG_GOAL_X        = 3'd2,
      REG_GOAL_Y        = 3'd3,
      REG_STRAIGHT_COST = 3'd4,
      REG_DIAGONAL_COST = 3'd5
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_EXPAND = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_NONE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2,
      PH_DONE   = 2'd3
   } sub_phase_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_EXP_INIT,
      ST_LOAD,
      ST_DIRS,
      ST_NEXT_DIR,
      ST_EVAL,
      ST_FOUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic wr_read;
      logic wr_write;
      logic exp_init;
      logic load;
      logic dirs_set;
      logic dir_start;
      logic sub_launch1;
      logic sub_launch2;
      logic sub_end;
      logic advance;
      logic record;
      logic emit_pend;
      logic emit_final;
   } ctrl_cmd_type;

   typedef struct packed {
      logic          clear_done;
      logic          store_ok;
      logic          in_grid;
      logic          load_done;
      logic          win_hit;
      logic          dirs_empty;
      logic          ev_hit;
      logic          reach_ok;
      logic          sub_active;
      sub_phase_type sub_phase;
      logic          main_diag;
      logic          main_moved;
      logic          pend_valid;
      logic          out_free;
   } dp_status_type;

   // neighbor bit k is the cell one step from the probe in direction k
   function automatic logic reach_diag(input logic [7:0] nb, input logic [2:0] k);
      logic [2:0] km;
      logic [2:0] kp;
      km = k - 3'd1;
      kp = k + 3'd1;
      return nb[k] & (nb[km] | nb[kp]);
   endfunction

   function automatic logic [7:0] forced_dirs(input logic [7:0] nb, input logic [3:0] dir);
      logic [2:0] d;
      logic [2:0] a;
      logic [2:0] b;
      logic [2:0] c;
      logic [2:0] e;
      logic [7:0] m;
      d = dir[2:0];
      m = '0;
      if (d[0]) begin
         a = d + 3'd6;
         b = d + 3'd5;
         c = d + 3'd2;
         e = d + 3'd3;
      end else begin
         a = d + 3'd1;
         b = d + 3'd2;
         c = d + 3'd7;
         e = d + 3'd6;
      end
      if (reach_diag(nb, a) && !nb[b]) m[a] = 1'b1;
      if (reach_diag(nb, c) && !nb[e]) m[c] = 1'b1;
      if (dir[3]) m = '0;
      return m;
   endfunction

   function automatic logic [7:0] natural_dirs(input logic [3:0] dir);
      logic [2:0] d;
      logic [2:0] dm;
      logic [2:0] dp;
      logic [7:0] m;
      d  = dir[2:0];
      dm = d - 3'd1;
      dp = d + 3'd1;
      m  = '0;
      m[d] = 1'b1;
      if (d[0]) begin
         m[dm] = 1'b1;
         m[dp] = 1'b1;
      end
      if (dir[3]) m = DIR_MASK_ALL;
      return m;
   endfunction

   function automatic logic [3:0] parent_dir(input logic signed [6:0] dx,
                                             input logic signed [6:0] dy);
      logic [3:0] r;
      r = DIR_NONE;
      if (dx == 0 && dy < 0) r = 4'd0;
      if (dx > 0 && dy < 0) r = 4'd1;
      if (dx > 0 && dy == 0) r = 4'd2;
      if (dx > 0 && dy > 0) r = 4'd3;
      if (dx == 0 && dy > 0) r = 4'd4;
      if (dx < 0 && dy > 0) r = 4'd5;
      if (dx < 0 && dy == 0) r = 4'd6;
      if (dx < 0 && dy < 0) r = 4'd7;
      return r;
   endfunction

   function automatic logic [2:0] lowest_dir(input logic [7:0] m);
      logic [2:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         if (m[i]) r = 3'(i);
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] step_x(input logic [COORD_W-1:0] x,
                                                 input logic [2:0] d);
      logic [COORD_W-1:0] r;
      unique case (d) inside
         3'd1, 3'd2, 3'd3: r = x + 1'b1;
         3'd5, 3'd6, 3'd7: r = x - 1'b1;
         default:          r = x;
      endcase
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] step_y(input logic [COORD_W-1:0] y,
                                                 input logic [2:0] d);
      logic [COORD_W-1:0] r;
      unique case (d) inside
         3'd7, 3'd0, 3'd1: r = y - 1'b1;
         3'd3, 3'd4, 3'd5: r = y + 1'b1;
         default:          r = y;
      endcase
      return r;
   endfunction

endpackage

[src/jpss_datapath.sv]
// Datapath: grid memory, row window, scan registers, pending jump point and output beat.
module jpss_datapath #(
   parameter int MAX_WIDTH  = jpss_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = jpss_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jpss_pkg::ctrl_cmd_type              cmd,
   output jpss_pkg::dp_status_type             status,
   input  logic [jpss_pkg::COORD_W-1:0]        req_node_x,
   input  logic [jpss_pkg::COORD_W-1:0]        req_node_y,
   input  logic                                req_cell_open,
   input  logic                                req_has_parent,
   input  logic [jpss_pkg::COORD_W-1:0]        req_parent_x,
   input  logic [jpss_pkg::COORD_W-1:0]        req_parent_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [jpss_pkg::COORD_W-1:0]        rsp_succ_x,
   output logic [jpss_pkg::COORD_W-1:0]        rsp_succ_y,
   output logic [jpss_pkg::COST_W-1:0]         rsp_step_cost,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [jpss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jpss_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int SW = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
   localparam int SH = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
   localparam int CW = $clog2(SW);
   localparam int RW = $clog2(SH);
   localparam logic [6:0] SW7 = 7'(SW);
   localparam logic [6:0] SH7 = 7'(SH);
   localparam int XW = jpss_pkg::COORD_W;

   // configuration
   logic [6:0]    gw_ff, gh_ff;
   logic [XW-1:0] goal_x_ff, goal_y_ff;
   logic [7:0]    sc_ff, dc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff     <= 7'd64;
         gh_ff     <= 7'd64;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         sc_ff     <= 8'd10;
         dc_ff     <= 8'd14;
      end else if (csr_write_enable) begin
         case (csr_index)
            jpss_pkg::REG_GRID_WIDTH:    gw_ff     <= csr_write_data[6:0];
            jpss_pkg::REG_GRID_HEIGHT:   gh_ff     <= csr_write_data[6:0];
            jpss_pkg::REG_GOAL_X:        goal_x_ff <= csr_write_data[XW-1:0];
            jpss_pkg::REG_GOAL_Y:        goal_y_ff <= csr_write_data[XW-1:0];
            jpss_pkg::REG_STRAIGHT_COST: sc_ff     <= csr_write_data;
            jpss_pkg::REG_DIAGONAL_COST: dc_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [6:0]    used_w, used_h;
   logic [SW-1:0] col_mask;

   assign used_w = (gw_ff > SW7) ? SW7 : gw_ff;
   assign used_h = (gh_ff > SH7) ? SH7 : gh_ff;

   always_comb begin
      for (int c = 0; c < SW; c++) begin
         col_mask[c] = (7'(c) < used_w);
      end
   end

   // request latch
   logic          open_ff, hp_ff;
   logic [XW-1:0] nx_ff, ny_ff, px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nx_ff   <= req_node_x;
         ny_ff   <= req_node_y;
         open_ff <= req_cell_open;
         hp_ff   <= req_has_parent;
         px_ff   <= req_parent_x;
         py_ff   <= req_parent_y;
      end
   end

   // grid memory, one row per word
   logic [SW-1:0] map_mem [SH];
   logic [SW-1:0] rd_ff;
   logic [RW-1:0] clr_cnt_ff;
   logic [RW-1:0] mem_raddr, mem_waddr;
   logic [SW-1:0] mem_wdata;
   logic          mem_we;
   logic [7:0]    ld_row;
   logic [1:0]    ld_cnt_ff;

   always_comb begin
      mem_we    = cmd.clear | cmd.wr_write;
      mem_waddr = cmd.clear ? clr_cnt_ff : ny_ff[RW-1:0];
      mem_wdata = rd_ff;
      mem_wdata[nx_ff[CW-1:0]] = open_ff;
      if (cmd.clear) mem_wdata = '0;
      mem_raddr = cmd.wr_read ? ny_ff[RW-1:0] : ld_row[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_waddr] <= mem_wdata;
      rd_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // scan registers
   logic [3:0]    pd_ff;
   logic [7:0]    dirs_ff;
   logic [2:0]    mdir_ff, sdir_ff;
   logic [XW-1:0] mx_ff, my_ff, sx_ff, sy_ff;
   logic          mmoved_ff, smoved_ff, sub_active_ff;
   jpss_pkg::sub_phase_type sub_phase_ff;
   logic [jpss_pkg::COST_W-1:0] cost_ff;
   logic [7:0]    unit_ff;

   logic [XW-1:0] act_x, act_y;
   logic [2:0]    act_dir;
   logic          act_moved;

   assign act_x     = sub_active_ff ? sx_ff : mx_ff;
   assign act_y     = sub_active_ff ? sy_ff : my_ff;
   assign act_dir   = sub_active_ff ? sdir_ff : mdir_ff;
   assign act_moved = sub_active_ff ? smoved_ff : mmoved_ff;

   // three-row window around the probe row
   logic [SW-1:0] win_top_ff, win_mid_ff, win_bot_ff, cap_row;
   logic [XW-1:0] win_y_ff;
   logic          win_ok_ff, rv_ff;

   assign ld_row  = {2'b00, act_y} + {6'b000000, ld_cnt_ff} - 8'd1;
   assign cap_row = rv_ff ? (rd_ff & col_mask) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_cnt_ff <= '0;
         win_ok_ff <= 1'b0;
      end else begin
         if (cmd.exp_init) win_ok_ff <= 1'b0;
         if (cmd.load) begin
            ld_cnt_ff <= ld_cnt_ff + 1'b1;
            if (ld_cnt_ff == 2'd3) win_ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rv_ff <= (ld_row < {1'b0, used_h});
         case (ld_cnt_ff)
            2'd1:    win_top_ff <= cap_row;
            2'd2:    win_mid_ff <= cap_row;
            2'd3: begin
               win_bot_ff <= cap_row;
               win_y_ff   <= act_y;
            end
            default: ;
         endcase
      end
   end

   // neighborhood of the probe cell
   logic [XW-1:0] xp6, xm6;
   logic [CW-1:0] xi, xpi, xmi;
   logic          xp_ok, xm_ok;
   logic [7:0]    nb;

   assign xp6   = act_x + 1'b1;
   assign xm6   = act_x - 1'b1;
   assign xi    = act_x[CW-1:0];
   assign xpi   = xp6[CW-1:0];
   assign xmi   = xm6[CW-1:0];
   assign xp_ok = ({1'b0, act_x} + 7'd1) < SW7;
   assign xm_ok = (act_x != '0);

   always_comb begin
      nb[0] = win_top_ff[xi];
      nb[1] = xp_ok & win_top_ff[xpi];
      nb[2] = xp_ok & win_mid_ff[xpi];
      nb[3] = xp_ok & win_bot_ff[xpi];
      nb[4] = win_bot_ff[xi];
      nb[5] = xm_ok & win_bot_ff[xmi];
      nb[6] = xm_ok & win_mid_ff[xmi];
      nb[7] = xm_ok & win_top_ff[xmi];
   end

   logic          goal_hit, diag_eval, reach_ok, ev_hit;
   logic [2:0]    first_dir;
   logic signed [6:0] pdx, pdy;

   assign goal_hit  = (act_x == goal_x_ff) && (act_y == goal_y_ff);
   assign diag_eval = !sub_active_ff && mdir_ff[0];
   assign reach_ok  = diag_eval ? jpss_pkg::reach_diag(nb, act_dir) : nb[act_dir];
   assign ev_hit    = act_moved &&
                      (goal_hit || (jpss_pkg::forced_dirs(nb, {1'b0, act_dir}) != '0));
   assign first_dir = jpss_pkg::lowest_dir(dirs_ff);
   assign pdx       = $signed({1'b0, nx_ff}) - $signed({1'b0, px_ff});
   assign pdy       = $signed({1'b0, ny_ff}) - $signed({1'b0, py_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_active_ff <= 1'b0;
         sub_phase_ff  <= jpss_pkg::PH_NONE;
      end else begin
         if (cmd.exp_init || cmd.dir_start || cmd.record) begin
            sub_active_ff <= 1'b0;
            sub_phase_ff  <= jpss_pkg::PH_NONE;
         end
         if (cmd.sub_launch1) begin
            sub_active_ff <= 1'b1;
            sub_phase_ff  <= jpss_pkg::PH_FIRST;
         end
         if (cmd.sub_launch2) sub_phase_ff <= jpss_pkg::PH_SECOND;
         if (cmd.sub_end) begin
            sub_active_ff <= 1'b0;
            sub_phase_ff  <= jpss_pkg::PH_DONE;
         end
         if (cmd.advance && !sub_active_ff) sub_phase_ff <= jpss_pkg::PH_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_init) begin
         pd_ff     <= hp_ff ? jpss_pkg::parent_dir(pdx, pdy) : jpss_pkg::DIR_NONE;
         mx_ff     <= nx_ff;
         my_ff     <= ny_ff;
         mmoved_ff <= 1'b0;
      end
      if (cmd.dirs_set) begin
         dirs_ff <= jpss_pkg::natural_dirs(pd_ff) | jpss_pkg::forced_dirs(nb, pd_ff);
      end
      if (cmd.dir_start) begin
         dirs_ff[first_dir] <= 1'b0;
         mdir_ff   <= first_dir;
         mx_ff     <= nx_ff;
         my_ff     <= ny_ff;
         mmoved_ff <= 1'b0;
         cost_ff   <= '0;
         unit_ff   <= first_dir[0] ? dc_ff : sc_ff;
      end
      if (cmd.sub_launch1 || cmd.sub_launch2) begin
         sdir_ff   <= cmd.sub_launch1 ? (mdir_ff - 3'd1) : (mdir_ff + 3'd1);
         sx_ff     <= mx_ff;
         sy_ff     <= my_ff;
         smoved_ff <= 1'b0;
      end
      if (cmd.advance) begin
         if (sub_active_ff) begin
            sx_ff     <= jpss_pkg::step_x(sx_ff, sdir_ff);
            sy_ff     <= jpss_pkg::step_y(sy_ff, sdir_ff);
            smoved_ff <= 1'b1;
         end else begin
            mx_ff     <= jpss_pkg::step_x(mx_ff, mdir_ff);
            my_ff     <= jpss_pkg::step_y(my_ff, mdir_ff);
            mmoved_ff <= 1'b1;
            cost_ff   <= cost_ff + {6'b000000, unit_ff};
         end
      end
   end

   // pending jump point and output beat
   logic                        pend_valid_ff;
   logic [XW-1:0]               pend_x_ff, pend_y_ff;
   logic [jpss_pkg::COST_W-1:0] pend_cost_ff;
   logic                        rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [XW-1:0]               rsp_x_ff, rsp_y_ff;
   logic [jpss_pkg::COST_W-1:0] rsp_cost_ff;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.exp_init || cmd.emit_final) pend_valid_ff <= 1'b0;
         if (cmd.record) pend_valid_ff <= 1'b1;
         if (cmd.emit_pend || cmd.emit_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.record) begin
         pend_x_ff    <= mx_ff;
         pend_y_ff    <= my_ff;
         pend_cost_ff <= cost_ff;
      end
      if (cmd.emit_pend || cmd.emit_final) begin
         rsp_found_ff <= pend_valid_ff;
         rsp_x_ff     <= pend_valid_ff ? pend_x_ff : '0;
         rsp_y_ff     <= pend_valid_ff ? pend_y_ff : '0;
         rsp_cost_ff  <= pend_valid_ff ? pend_cost_ff : '0;
         rsp_last_ff  <= cmd.emit_final;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_succ_x    = rsp_x_ff;
   assign rsp_succ_y    = rsp_y_ff;
   assign rsp_step_cost = rsp_cost_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      status            = '0;
      status.clear_done = (clr_cnt_ff == RW'(SH - 1));
      status.store_ok   = ({1'b0, nx_ff} < SW7) && ({1'b0, ny_ff} < SH7);
      status.in_grid    = ({1'b0, nx_ff} < used_w) && ({1'b0, ny_ff} < used_h);
      status.load_done  = (ld_cnt_ff == 2'd3);
      status.win_hit    = win_ok_ff && (win_y_ff == act_y);
      status.dirs_empty = (dirs_ff == '0);
      status.ev_hit     = ev_hit;
      status.reach_ok   = reach_ok;
      status.sub_active = sub_active_ff;
      status.sub_phase  = sub_phase_ff;
      status.main_diag  = mdir_ff[0];
      status.main_moved = mmoved_ff;
      status.pend_valid = pend_valid_ff;
      status.out_free   = out_free;
   end

   a_sub_on_diag: assert property (@(posedge clock) disable iff (reset)
      sub_active_ff |-> mdir_ff[0])
      else $error("straight sub-scan running under a straight main scan");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pend || cmd.emit_final) |-> out_free)
      else $error("beat loaded over a held beat");

   a_advance_open: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (reach_ok && win_ok_ff && (win_y_ff == act_y)))
      else $error("scan advanced into a closed cell or without a window");

   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (!pend_valid_ff && !sub_active_ff))
      else $error("request taken with expansion state left over");

endmodule

[src/jpss_ctrl.sv]
// Controller state machine sequencing clears, writes, window loads and jump scans.
module jpss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_type,
   output logic                    req_stall,
   input  jpss_pkg::dp_status_type status,
   output jpss_pkg::ctrl_cmd_type  cmd
);

   jpss_pkg::state_type state_ff, state_in;
   jpss_pkg::state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jpss_pkg::ST_CLEAR;
         ret_ff   <= jpss_pkg::ST_EVAL;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      unique case (state_ff)
         jpss_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = jpss_pkg::ST_IDLE;
         end
         jpss_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = (req_type == jpss_pkg::REQ_WRITE) ? jpss_pkg::ST_WR_READ
                                                            : jpss_pkg::ST_EXP_INIT;
            end
         end
         jpss_pkg::ST_WR_READ: begin
            if (status.store_ok) begin
               cmd.wr_read = 1'b1;
               state_in = jpss_pkg::ST_WR_WRITE;
            end else begin
               state_in = jpss_pkg::ST_IDLE;
            end
         end
         jpss_pkg::ST_WR_WRITE: begin
            cmd.wr_write = 1'b1;
            state_in = jpss_pkg::ST_IDLE;
         end
         jpss_pkg::ST_EXP_INIT: begin
            cmd.exp_init = 1'b1;
            state_in = status.in_grid ? jpss_pkg::ST_DIRS : jpss_pkg::ST_FINISH;
         end
         jpss_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.load_done) state_in = ret_ff;
         end
         jpss_pkg::ST_DIRS: begin
            if (!status.win_hit) begin
               ret_in   = jpss_pkg::ST_DIRS;
               state_in = jpss_pkg::ST_LOAD;
            end else begin
               cmd.dirs_set = 1'b1;
               state_in = jpss_pkg::ST_NEXT_DIR;
            end
         end
         jpss_pkg::ST_NEXT_DIR: begin
            if (status.dirs_empty) begin
               state_in = jpss_pkg::ST_FINISH;
            end else begin
               cmd.dir_start = 1'b1;
               state_in = jpss_pkg::ST_EVAL;
            end
         end
         jpss_pkg::ST_EVAL: begin
            if (!status.win_hit) begin
               ret_in   = jpss_pkg::ST_EVAL;
               state_in = jpss_pkg::ST_LOAD;
            end else if (status.ev_hit) begin
               state_in = jpss_pkg::ST_FOUND;
            end else if (!status.sub_active && status.main_diag && status.main_moved &&
                         status.sub_phase == jpss_pkg::PH_NONE) begin
               cmd.sub_launch1 = 1'b1;
            end else if (!status.reach_ok) begin
               if (!status.sub_active) begin
                  state_in = jpss_pkg::ST_NEXT_DIR;
               end else if (status.sub_phase == jpss_pkg::PH_FIRST) begin
                  cmd.sub_launch2 = 1'b1;
               end else begin
                  cmd.sub_end = 1'b1;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         jpss_pkg::ST_FOUND: begin
            if (!status.pend_valid) begin
               cmd.record = 1'b1;
               state_in = jpss_pkg::ST_NEXT_DIR;
            end else if (status.out_free) begin
               cmd.emit_pend = 1'b1;
               cmd.record    = 1'b1;
               state_in = jpss_pkg::ST_NEXT_DIR;
            end
         end
         jpss_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit_final = 1'b1;
               state_in = jpss_pkg::ST_IDLE;
            end
         end
         default: state_in = jpss_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != jpss_pkg::ST_IDLE);

endmodule

[src/jump_point_successor_search.sv]
// Top level of the jump point successor search: controller and datapath.
//
//   channel   direction  handshake                  beat
//   req_      in         req_valid / req_stall      cell write or node expansion
//   rsp_      out        rsp_valid / rsp_stall      one jump point, last marks the end
//   csr_      in         csr_write_enable           register index and data
//
// After reset a clearing pass of MAX_HEIGHT rows (at most 64 rows) blocks req_.
// A cell write reads its grid row and writes it back with the cell changed. An
// expansion takes data-dependent time: each window load brings three grid rows
// through the single read port, and every change of row in a scan reloads the
// window. One item is in work at a time; a held rsp_ beat stalls the scan only
// when the next jump point or the final beat is ready.
module jump_point_successor_search #(
   parameter int MAX_WIDTH  = jpss_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = jpss_pkg::DEF_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [jpss_pkg::COORD_W-1:0]     req_node_x,
   input  logic [jpss_pkg::COORD_W-1:0]     req_node_y,
   input  logic                             req_cell_open,
   input  logic                             req_has_parent,
   input  logic [jpss_pkg::COORD_W-1:0]     req_parent_x,
   input  logic [jpss_pkg::COORD_W-1:0]     req_parent_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_found,
   output logic [jpss_pkg::COORD_W-1:0]     rsp_succ_x,
   output logic [jpss_pkg::COORD_W-1:0]     rsp_succ_y,
   output logic [jpss_pkg::COST_W-1:0]      rsp_step_cost,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [jpss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jpss_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   jpss_pkg::ctrl_cmd_type  cmd;
   jpss_pkg::dp_status_type status;

   jpss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   jpss_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_node_x       (req_node_x),
      .req_node_y       (req_node_y),
      .req_cell_open    (req_cell_open),
      .req_has_parent   (req_has_parent),
      .req_parent_x     (req_parent_x),
      .req_parent_y     (req_parent_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_succ_x       (rsp_succ_x),
      .rsp_succ_y       (rsp_succ_y),
      .rsp_step_cost    (rsp_step_cost),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

[tb/sv/jump_point_successor_search_test.sv]
// Self-checking testbench for the jump point successor search block.
module jump_point_successor_search_test;

   localparam int STALL_LIMIT = 400000;

   typedef struct {
      bit         found;
      bit [5:0]   sx;
      bit [5:0]   sy;
      bit [13:0]  cost;
      bit         last;
   } jump_point_type;

   typedef struct {
      jpss_pkg::req_kind_type kind;
      bit [5:0]     x;
      bit [5:0]     y;
      bit           open;
      bit           has_par;
      bit [5:0]     px;
      bit [5:0]     py;
   } grid_req_type;

   class successor_ledger;
      bit             cells [4096];
      int             width_reg = 64, height_reg = 64, goal_x = 0, goal_y = 0;
      int             straight_unit = 10, diagonal_unit = 14;
      jump_point_type pending [$];
      int             errors, beats;

      function void set_reg(jpss_pkg::csr_index_type idx, bit [7:0] val);
         case (idx)
            jpss_pkg::REG_GRID_WIDTH:    width_reg = val & 8'h7F;
            jpss_pkg::REG_GRID_HEIGHT:   height_reg = val & 8'h7F;
            jpss_pkg::REG_GOAL_X:        goal_x = val & 8'h3F;
            jpss_pkg::REG_GOAL_Y:        goal_y = val & 8'h3F;
            jpss_pkg::REG_STRAIGHT_COST: straight_unit = val;
            jpss_pkg::REG_DIAGONAL_COST: diagonal_unit = val;
            default: ;
         endcase
      endfunction

      function bit in_grid(int x, int y);
         return x >= 0 && y >= 0 && x < (width_reg > 64 ? 64 : width_reg)
                && y < (height_reg > 64 ? 64 : height_reg);
      endfunction

      function bit open_at(int x, int y);
         if (!in_grid(x, y)) return 0;
         return cells[y * 64 + x];
      endfunction

      function int ddx(int d);
         case (d & 7)
            1, 2, 3: return 1;
            5, 6, 7: return -1;
            default: return 0;
         endcase
      endfunction

      function int ddy(int d);
         case (d & 7)
            7, 0, 1: return -1;
            3, 4, 5: return 1;
            default: return 0;
         endcase
      endfunction

      function bit reach(int x, int y, int d, bit diag);
         d = d & 7;
         if (diag && !reach(x, y, d + 7, 0) && !reach(x, y, d + 1, 0)) return 0;
         return open_at(x + ddx(d), y + ddy(d));
      endfunction

      function bit [7:0] forced(int x, int y, int d);
         bit [7:0] m;
         m = 0;
         if (d >= 8) return 0;
         if (d & 1) begin
            if (reach(x, y, d + 6, 1) && !reach(x, y, d + 5, 0)) m[(d + 6) & 7] = 1;
            if (reach(x, y, d + 2, 1) && !reach(x, y, d + 3, 0)) m[(d + 2) & 7] = 1;
         end else begin
            if (reach(x, y, d + 1, 1) && !reach(x, y, d + 2, 0)) m[(d + 1) & 7] = 1;
            if (reach(x, y, d + 7, 1) && !reach(x, y, d + 6, 0)) m[(d + 7) & 7] = 1;
         end
         return m;
      endfunction

      function bit at_goal(int x, int y);
         return x == goal_x && y == goal_y;
      endfunction

      function bit run_line(int x, int y, int d, output int ox, output int oy, output int n);
         n = 0;
         forever begin
            if (!reach(x, y, d, 0)) return 0;
            x += ddx(d);
            y += ddy(d);
            n++;
            if (at_goal(x, y) || forced(x, y, d) != 0) begin
               ox = x;
               oy = y;
               return 1;
            end
         end
      endfunction

      function bit run_ray(int x, int y, int d, output int ox, output int oy, output int n);
         int tx, ty, tn;
         if (!(d & 1)) return run_line(x, y, d, ox, oy, n);
         n = 0;
         forever begin
            if (!reach(x, y, d, 1)) return 0;
            x += ddx(d);
            y += ddy(d);
            n++;
            if (at_goal(x, y) || forced(x, y, d) != 0 ||
                run_line(x, y, (d + 7) & 7, tx, ty, tn) ||
                run_line(x, y, (d + 1) & 7, tx, ty, tn)) begin
               ox = x;
               oy = y;
               return 1;
            end
         end
      endfunction

      function int heading(int dx, int dy);
         if (dx == 0 && dy < 0) return 0;
         if (dx > 0 && dy < 0) return 1;
         if (dx > 0 && dy == 0) return 2;
         if (dx > 0 && dy > 0) return 3;
         if (dx == 0 && dy > 0) return 4;
         if (dx < 0 && dy > 0) return 5;
         if (dx < 0 && dy == 0) return 6;
         if (dx < 0 && dy < 0) return 7;
         return 8;
      endfunction

      function void note_request(grid_req_type r);
         int             d, sx, sy, n, c, first;
         bit [7:0]       dirs;
         jump_point_type jp;
         if (r.kind == jpss_pkg::REQ_WRITE) begin
            cells[r.y * 64 + r.x] = r.open;
            return;
         end
         first = pending.size();
         if (in_grid(r.x, r.y)) begin
            d = r.has_par ? heading(int'(r.x) - int'(r.px), int'(r.y) - int'(r.py)) : 8;
            if (d == 8) dirs = jpss_pkg::DIR_MASK_ALL;
            else begin
               dirs = 0;
               dirs[d] = 1;
               if (d & 1) begin
                  dirs[(d + 1) & 7] = 1;
                  dirs[(d + 7) & 7] = 1;
               end
            end
            dirs |= forced(r.x, r.y, d);
            for (int k = 0; k < 8; k++) begin
               if (dirs[k] && run_ray(r.x, r.y, k, sx, sy, n)) begin
                  c = ((k & 1) ? diagonal_unit : straight_unit) * n;
                  if (c > 16383) c = 16383;
                  jp.found = 1;
                  jp.sx = sx;
                  jp.sy = sy;
                  jp.cost = c;
                  jp.last = 0;
                  pending = {pending, jp};
               end
            end
         end
         if (pending.size() == first) begin
            jp = '{0, 0, 0, 0, 1};
            pending = {pending, jp};
         end else
            pending[pending.size() - 1].last = 1;
      endfunction

      function void check_beat(jump_point_type got);
         jump_point_type want;
         beats++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: found %0d (%0d,%0d) cost %0d last %0d", $time,
                     got.found, got.sx, got.sy, got.cost, got.last);
            return;
         end
         want = pending.pop_front();
         if (want.found != got.found || want.sx != got.sx || want.sy != got.sy ||
             want.cost != got.cost || want.last != got.last) begin
            errors++;
            $display("%0t mismatch: expected %0d (%0d,%0d) cost %0d last %0d",
                     $time, want.found, want.sx, want.sy, want.cost, want.last);
            $display("%0t          actual %0d (%0d,%0d) cost %0d last %0d",
                     $time, got.found, got.sx, got.sy, got.cost, got.last);
         end
      endfunction
   endclass

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             req_valid = 0;
   logic                             req_stall;
   logic                             req_type = 0;
   logic [jpss_pkg::COORD_W-1:0]     req_node_x = 0, req_node_y = 0;
   logic [jpss_pkg::COORD_W-1:0]     req_parent_x = 0, req_parent_y = 0;
   logic                             req_cell_open = 0, req_has_parent = 0;
   logic                             rsp_valid;
   logic                             rsp_stall = 0;
   logic                             rsp_found, rsp_last;
   logic [jpss_pkg::COORD_W-1:0]     rsp_succ_x, rsp_succ_y;
   logic [jpss_pkg::COST_W-1:0]      rsp_step_cost;
   logic                             csr_write_enable = 0;
   logic [jpss_pkg::CSR_INDEX_W-1:0] csr_index = 0;
   logic [jpss_pkg::CSR_DATA_W-1:0]  csr_write_data = 0;

   successor_ledger ledger = new();
   bit              hold_rsp = 0;
   int              quiet_cycles = 0;
   int              n_writes = 0, n_expands = 0;

   jump_point_successor_search dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_beat('{rsp_found, rsp_succ_x, rsp_succ_y, rsp_step_cost, rsp_last});
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random holds, plus one long hold on request
   always begin
      int r;
      @(posedge clock);
      if (hold_rsp) begin
         rsp_stall <= 1;
         repeat (500) @(posedge clock);
         hold_rsp = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else if (r < 90) begin
            rsp_stall <= 1;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_stall <= 1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(grid_req_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1;
      req_type       <= it.kind;
      req_node_x     <= it.x;
      req_node_y     <= it.y;
      req_cell_open  <= it.open;
      req_has_parent <= it.has_par;
      req_parent_x   <= it.px;
      req_parent_y   <= it.py;
      do @(posedge clock); while (!(req_valid && !req_stall));
      ledger.note_request(it);
      if (it.kind == jpss_pkg::REQ_WRITE) n_writes++;
      else n_expands++;
   endtask

   task automatic write_cell(int x, int y, bit open);
      send_item('{jpss_pkg::REQ_WRITE, x, y, open, 0, 0, 0});
   endtask

   task automatic expand(int x, int y, bit hp, int px, int py);
      send_item('{jpss_pkg::REQ_EXPAND, x, y, 0, hp, px, py});
   endtask

   task automatic drain();
      req_valid <= 0;
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic set_regs(bit [7:0] w, bit [7:0] h, bit [7:0] gx, bit [7:0] gy,
                           bit [7:0] sc, bit [7:0] dc);
      bit [7:0]                vals [6];
      jpss_pkg::csr_index_type idx;
      vals = '{w, h, gx, gy, sc, dc};
      drain();
      for (int i = 0; i < 6; i++) begin
         idx = jpss_pkg::csr_index_type'(i);
         csr_write_enable <= 1;
         csr_index      <= idx;
         csr_write_data <= vals[i];
         @(posedge clock);
         ledger.set_reg(idx, vals[i]);
      end
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int span_x, int span_y, int count);
      int           r, x, y, d, k, px, py;
      grid_req_type it;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         x = (r % 10 == 0) ? $urandom_range(0, 63) : $urandom_range(0, span_x - 1);
         y = (r % 10 == 1) ? $urandom_range(0, 63) : $urandom_range(0, span_y - 1);
         if (r < 35) begin
            write_cell(x, y, $urandom_range(0, 99) < 70);
         end else begin
            it = '{jpss_pkg::REQ_EXPAND, x, y, $urandom_range(0, 1), 0, 0, 0};
            r = $urandom_range(0, 99);
            if (r < 60) begin
               d = $urandom_range(0, 7);
               k = $urandom_range(1, 4);
               px = x - k * ((d inside {1, 2, 3}) ? 1 : (d inside {5, 6, 7}) ? -1 : 0);
               py = y - k * ((d inside {3, 4, 5}) ? 1 : (d inside {7, 0, 1}) ? -1 : 0);
               it.has_par = 1;
               it.px = (px < 0 || px > 63) ? $urandom_range(0, 63) : px;
               it.py = (py < 0 || py > 63) ? $urandom_range(0, 63) : py;
            end else if (r < 70) begin
               it.has_par = 1;
               it.px = x;
               it.py = y;
            end else if (r < 85) begin
               it.has_par = $urandom_range(0, 1);
               it.px = $urandom_range(0, 63);
               it.py = $urandom_range(0, 63);
            end
            send_item(it);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: small grid, cross of open cells through (3,3)
      set_regs(8, 8, 7, 3, 10, 14);
      expand(0, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++) write_cell(i, 3, 1);
      write_cell(3, 1, 1);
      write_cell(3, 2, 1);
      write_cell(3, 4, 1);
      write_cell(4, 4, 1);
      write_cell(63, 63, 1);
      write_cell(63, 63, 0);
      expand(3, 3, 0, 0, 0);
      expand(3, 3, 1, 3, 3);
      for (int d = 0; d < 8; d += 3) expand(3, 3, 1, 3 - d % 3 + 1, 3 + d / 4 - 1);
      expand(2, 3, 1, 1, 2);
      expand(10, 2, 1, 9, 2);
      expand(63, 63, 1, 0, 0);

      set_regs(10, 10, $urandom_range(0, 9), $urandom_range(0, 9), 10, 14);
      hold_rsp = 1;
      random_phase(10, 10, 45);
      set_regs(6, 12, 63, 63, 0, 255);
      random_phase(6, 12, 40);
      set_regs(0, 5, 0, 0, 255, 0);
      random_phase(8, 8, 20);
      set_regs(1, 1, 0, 0, 1, 1);
      random_phase(2, 2, 15);
      set_regs(127, 255, $urandom_range(0, 63), $urandom_range(0, 63), 255, 255);
      random_phase(64, 64, 40);
      set_regs(16, 64, $urandom_range(0, 15), $urandom_range(0, 15),
               $urandom_range(0, 255), $urandom_range(0, 255));
      random_phase(12, 12, 50);
      set_regs(12, 12, $urandom_range(0, 11), $urandom_range(0, 11), 10, 14);
      random_phase(12, 12, 55);
      drain();

      $display("covered %0d cell writes and %0d expansions, %0d result beats checked",
               n_writes, n_expands, ledger.beats);
      $display("grid sizes from 0 to 64, unit costs 0 to 255, one long receiver hold");
      if (ledger.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
